@@ hdl/tcp_ipv4_header_extractor_assert.svh @@
// ----------------------------------------------------------------------------
// TCP/IPv4 header extractor assertion macros
// Shared property forms for the header extractor; clocked on clk and
// disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef TCP_IPV4_HEADER_EXTRACTOR_ASSERT_SVH
`define TCP_IPV4_HEADER_EXTRACTOR_ASSERT_SVH

// Same-cycle implication.
`define TCPHDR_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define TCPHDR_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hdl/tcphdr_pkg.sv @@
// ----------------------------------------------------------------------------
// TCP/IPv4 header extractor package
// Frame layout constants, option codes and the item types of both channels.
// ----------------------------------------------------------------------------
package tcphdr_pkg;

  localparam int ETH_HEADER_BYTES = 14;
  localparam int IP_HEADER_BYTES  = 20;
  localparam int TCP_START        = ETH_HEADER_BYTES + IP_HEADER_BYTES;
  localparam int TCP_MIN_HDR      = 20;
  localparam int POS_W            = 7;
  localparam int POS_MAX          = (1 << POS_W) - 1;
  localparam int REM_W            = 6;
  localparam int REM_MAX          = (1 << REM_W) - 1;

  // IPv4 header offsets of the address words
  localparam int IP_SRC_OFS = 12;
  localparam int IP_DST_OFS = 16;

  // TCP header offsets
  localparam int TCP_SEQ_OFS    = 4;
  localparam int TCP_ACK_OFS    = 8;
  localparam int TCP_DOFF_OFS   = 12;
  localparam int TCP_FLAGS_OFS  = 13;
  localparam int TCP_WIN_HI_OFS = 14;
  localparam int TCP_WIN_LO_OFS = 15;

  // Option kinds
  localparam logic [7:0] KIND_END    = 8'd0;
  localparam logic [7:0] KIND_NOP    = 8'd1;
  localparam logic [7:0] KIND_WSCALE = 8'd3;
  localparam logic [7:0] OPT_MIN_LEN = 8'd2;

  typedef enum logic [1:0] {
    PH_KIND = 2'd0,
    PH_LEN  = 2'd1,
    PH_DATA = 2'd2,
    PH_DONE = 2'd3
  } opt_phase_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_item_t;

  typedef struct packed {
    logic [31:0] source_address;
    logic [31:0] dest_address;
    logic [15:0] source_port;
    logic [15:0] dest_port;
    logic [31:0] sequence_number;
    logic [31:0] ack_number;
    logic [5:0]  flag_bits;
    logic [15:0] window_size;
    logic [5:0]  tcp_header_bytes;
    logic        has_window_scale;
    logic [7:0]  window_scale;
    logic        status;
  } out_item_t;

  // Window scale capture: seen flag and shift byte
  typedef struct packed {
    logic       seen;
    logic [7:0] value;
  } wscale_t;

  // Control from the field stage to the option walker
  typedef struct packed {
    logic advance;    // a byte is processed this cycle
    logic frame_end;  // that byte closes the frame
    logic in_window;  // byte lies in the options area
  } opt_ctl_t;

endpackage

@@ hdl/tcphdr_opt_walk.sv @@
// ----------------------------------------------------------------------------
// TCP option walker
// Steps through the option list one byte per cycle while bytes advance, and
// captures the first window scale shift.
// ----------------------------------------------------------------------------
module tcphdr_opt_walk (
  input  logic                  clk,
  input  logic                  rst_n,
  input  tcphdr_pkg::opt_ctl_t  ctl,
  input  logic [7:0]            data,
  output tcphdr_pkg::wscale_t   scale_nxt
);
  import tcphdr_pkg::*;

  opt_phase_t       phase_r, phase_nxt;
  logic [REM_W-1:0] rem_r, rem_nxt;
  logic [7:0]       kind_r, kind_nxt;
  wscale_t          scale_r;
  logic             opt_en;
  logic [7:0]       len_m2;
  logic [REM_W-1:0] len_rem;

  assign opt_en  = ctl.in_window && (phase_r != PH_DONE);
  assign len_m2  = data - OPT_MIN_LEN;
  assign len_rem = (len_m2 > 8'(REM_MAX)) ? REM_W'(REM_MAX) : len_m2[REM_W-1:0];

  // Next phase
  always_comb begin
    phase_nxt = phase_r;
    if (opt_en) begin
      case (phase_r)
        PH_KIND: begin
          if (data == KIND_END) begin
            phase_nxt = PH_DONE;
          end else if (data != KIND_NOP) begin
            phase_nxt = PH_LEN;
          end
        end
        PH_LEN: begin
          if (data < OPT_MIN_LEN) begin
            phase_nxt = PH_DONE;
          end else if (len_rem != '0) begin
            phase_nxt = PH_DATA;
          end else begin
            phase_nxt = PH_KIND;
          end
        end
        PH_DATA: begin
          if (rem_r == REM_W'(1)) begin
            phase_nxt = PH_KIND;
          end
        end
        default: begin
          phase_nxt = phase_r;
        end
      endcase
    end
  end

  // Kind, remaining length and scale capture
  always_comb begin
    rem_nxt   = rem_r;
    kind_nxt  = kind_r;
    scale_nxt = scale_r;
    if (opt_en) begin
      case (phase_r)
        PH_KIND: begin
          kind_nxt = data;
        end
        PH_LEN: begin
          if (data >= OPT_MIN_LEN) begin
            rem_nxt = len_rem;
          end
        end
        PH_DATA: begin
          if ((kind_r == KIND_WSCALE) && !scale_r.seen) begin
            scale_nxt.seen  = 1'b1;
            scale_nxt.value = data;
          end
          rem_nxt = rem_r - REM_W'(1);
        end
        default: begin
          rem_nxt = rem_r;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || (ctl.advance && ctl.frame_end)) begin
      phase_r <= PH_KIND;
      rem_r   <= '0;
      kind_r  <= '0;
      scale_r <= '0;
    end else if (ctl.advance) begin
      phase_r <= phase_nxt;
      rem_r   <= rem_nxt;
      kind_r  <= kind_nxt;
      scale_r <= scale_nxt;
    end
  end

endmodule

@@ hdl/tcp_ipv4_header_extractor.sv @@
// ----------------------------------------------------------------------------
// TCP/IPv4 header extractor
// Parses an Ethernet/IPv4/TCP frame byte by byte and reports its header.
// ----------------------------------------------------------------------------
// Feed the frame one byte per item, starting at the Ethernet destination
// address, and mark the final byte with last_byte. The block takes one byte
// every cycle unless a closing byte stalls. Each byte is held in an input
// register and then updates the header fields. The sustained rate is one
// byte per clock outside such stalls; the result register is loaded from
// the input register. The 14-byte Ethernet header is skipped and a fixed
// 20-byte IPv4 header is assumed (IHL is not used). From the TCP header the
// ports, sequence, acknowledgment, six flag bits, window and data offset are
// kept, and the options are walked up to end-of-list or the data offset to
// pick up the first window scale shift. The frame-closing byte yields exactly
// one result item; status is 1 when the frame ended before the TCP header did,
// and fields of bytes that never arrived read as zero. A result waiting in
// the output register does not block ordinary bytes: only a closing byte
// stalls while the previous result is still held.
module tcp_ipv4_header_extractor (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  tcphdr_pkg::in_item_t  in_item,
  output logic                  out_valid,
  input  logic                  out_stall,
  output tcphdr_pkg::out_item_t out_item
);
  import tcphdr_pkg::*;

  `include "tcp_ipv4_header_extractor_assert.svh"

  // Input register
  logic     s1_valid_r;
  in_item_t s1_item_r;

  // Frame state
  logic [POS_W-1:0] pos_r, pos_nxt;
  logic [31:0]      src_r, src_nxt;
  logic [31:0]      dst_r, dst_nxt;
  logic [31:0]      ports_r, ports_nxt;
  logic [31:0]      seq_r, seq_nxt;
  logic [31:0]      ack_r, ack_nxt;
  logic [5:0]       flags_r, flags_nxt;
  logic [15:0]      win_r, win_nxt;
  logic [5:0]       hlen_r, hlen_nxt;

  // Result register
  logic      out_valid_r;
  out_item_t out_item_r;

  logic             out_free;
  logic             advance;
  logic             in_accept;
  logic [POS_W-1:0] ip_ofs;
  logic [POS_W-1:0] tcp_ofs;
  logic             in_ip;
  logic             in_tcp;
  logic [4:0]       lane;
  logic [7:0]       b;
  opt_ctl_t         opt_ctl;
  wscale_t          scale_nxt;
  logic [5:0]       hl_eff;
  logic [POS_W:0]   count;
  logic [POS_W:0]   needed;

  assign b        = s1_item_r.data_byte;
  assign out_free = !out_valid_r || !out_stall;
  // Hold a closing byte while the previous result still waits.
  assign advance   = s1_valid_r && (!s1_item_r.last_byte || out_free);
  assign in_stall  = s1_valid_r && !advance;
  assign in_accept = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_accept) begin
      s1_valid_r <= 1'b1;
    end else if (advance) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_item_r <= in_item;
    end
  end

  // Decode where the current byte falls in the frame.
  assign ip_ofs  = pos_r - POS_W'(ETH_HEADER_BYTES);
  assign tcp_ofs = pos_r - POS_W'(TCP_START);
  assign in_ip   = (pos_r >= POS_W'(ETH_HEADER_BYTES)) && (pos_r < POS_W'(TCP_START));
  assign in_tcp  = (pos_r >= POS_W'(TCP_START)) && (pos_r != POS_W'(POS_MAX));
  // Big-endian lane: offset 0 of a word lands in bits 31:24.
  assign lane    = {~(in_ip ? ip_ofs[1:0] : tcp_ofs[1:0]), 3'b000};

  always_comb begin
    pos_nxt   = (pos_r != POS_W'(POS_MAX)) ? (pos_r + POS_W'(1)) : pos_r;
    src_nxt   = src_r;
    dst_nxt   = dst_r;
    ports_nxt = ports_r;
    seq_nxt   = seq_r;
    ack_nxt   = ack_r;
    flags_nxt = flags_r;
    win_nxt   = win_r;
    hlen_nxt  = hlen_r;
    if (in_ip) begin
      if ((ip_ofs >= POS_W'(IP_SRC_OFS)) && (ip_ofs < POS_W'(IP_DST_OFS))) begin
        src_nxt[lane +: 8] = b;
      end else if (ip_ofs >= POS_W'(IP_DST_OFS)) begin
        dst_nxt[lane +: 8] = b;
      end
    end else if (in_tcp) begin
      if (tcp_ofs < POS_W'(TCP_SEQ_OFS)) begin
        ports_nxt[lane +: 8] = b;
      end else if (tcp_ofs < POS_W'(TCP_ACK_OFS)) begin
        seq_nxt[lane +: 8] = b;
      end else if (tcp_ofs < POS_W'(TCP_DOFF_OFS)) begin
        ack_nxt[lane +: 8] = b;
      end else if (tcp_ofs == POS_W'(TCP_DOFF_OFS)) begin
        // Data offset counts 32-bit words.
        hlen_nxt = {b[7:4], 2'b00};
      end else if (tcp_ofs == POS_W'(TCP_FLAGS_OFS)) begin
        flags_nxt = b[5:0];
      end else if (tcp_ofs == POS_W'(TCP_WIN_HI_OFS)) begin
        win_nxt[15:8] = b;
      end else if (tcp_ofs == POS_W'(TCP_WIN_LO_OFS)) begin
        win_nxt[7:0] = b;
      end
    end
  end

  // Options start after the fixed TCP header and end at the data offset.
  assign opt_ctl.advance   = advance;
  assign opt_ctl.frame_end = s1_item_r.last_byte;
  assign opt_ctl.in_window = in_tcp && (tcp_ofs >= POS_W'(TCP_MIN_HDR)) &&
                             (tcp_ofs < {1'b0, hlen_r});

  tcphdr_opt_walk u_opt_walk (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (opt_ctl),
    .data      (b),
    .scale_nxt (scale_nxt)
  );

  // Complete when the frame covered the TCP start plus max(20, data offset).
  assign hl_eff = (hlen_nxt > 6'(TCP_MIN_HDR)) ? hlen_nxt : 6'(TCP_MIN_HDR);
  assign count  = {1'b0, pos_r} + (POS_W+1)'(1);
  assign needed = (POS_W+1)'(TCP_START) + {{(POS_W-5){1'b0}}, hl_eff};

  always_ff @(posedge clk) begin
    if (!rst_n || (advance && s1_item_r.last_byte)) begin
      pos_r   <= '0;
      src_r   <= '0;
      dst_r   <= '0;
      ports_r <= '0;
      seq_r   <= '0;
      ack_r   <= '0;
      flags_r <= '0;
      win_r   <= '0;
      hlen_r  <= '0;
    end else if (advance) begin
      pos_r   <= pos_nxt;
      src_r   <= src_nxt;
      dst_r   <= dst_nxt;
      ports_r <= ports_nxt;
      seq_r   <= seq_nxt;
      ack_r   <= ack_nxt;
      flags_r <= flags_nxt;
      win_r   <= win_nxt;
      hlen_r  <= hlen_nxt;
    end
  end

  // Result register: load on a closing byte, hold while stalled.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance && s1_item_r.last_byte) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && s1_item_r.last_byte) begin
      out_item_r.source_address   <= src_nxt;
      out_item_r.dest_address     <= dst_nxt;
      out_item_r.source_port      <= ports_nxt[31:16];
      out_item_r.dest_port        <= ports_nxt[15:0];
      out_item_r.sequence_number  <= seq_nxt;
      out_item_r.ack_number       <= ack_nxt;
      out_item_r.flag_bits        <= flags_nxt;
      out_item_r.window_size      <= win_nxt;
      out_item_r.tcp_header_bytes <= hlen_nxt;
      out_item_r.has_window_scale <= scale_nxt.seen;
      out_item_r.window_scale     <= scale_nxt.value;
      out_item_r.status           <= (count < needed);
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  `TCPHDR_ASSERT_NEXT(a_frame_restart, advance && s1_item_r.last_byte, pos_r == '0,
    "byte position not cleared after frame end")
  `TCPHDR_ASSERT_NEXT(a_no_spurious_result, !out_valid_r && !(advance && s1_item_r.last_byte),
    !out_valid_r, "result appeared without a closing byte")
  `TCPHDR_ASSERT_NEXT(a_pos_advance,
    advance && !s1_item_r.last_byte && (pos_r != POS_W'(POS_MAX)),
    pos_r == $past(pos_r) + POS_W'(1), "byte position did not advance")
  `TCPHDR_ASSERT_NOW(a_no_overwrite, advance && s1_item_r.last_byte, out_free,
    "closing byte processed while result register is occupied")

endmodule

@@ tb/header_checker.sv @@
// ----------------------------------------------------------------------------
// TCP/IPv4 header extractor checker
// Watches both channels of the extractor, tracks each frame byte by byte to
// predict the header it reports, and compares every result item field by field.
// ----------------------------------------------------------------------------
module header_checker (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  input  logic                  in_stall,
  input  tcphdr_pkg::in_item_t  in_item,
  input  logic                  out_valid,
  input  logic                  out_stall,
  input  tcphdr_pkg::out_item_t out_item,
  output int                    errors,
  output int                    headers_due
);
  import tcphdr_pkg::*;

  // Frame tracking state
  logic [6:0]  frame_pos;
  logic [31:0] src_ip;
  logic [31:0] dst_ip;
  logic [15:0] src_port;
  logic [15:0] dst_port;
  logic [31:0] seq_no;
  logic [31:0] ack_no;
  logic [5:0]  tcp_flags;
  logic [15:0] rx_window;
  logic [5:0]  hdr_len;
  opt_phase_t  walk_phase;
  logic [5:0]  opt_left;
  logic [7:0]  opt_kind;
  wscale_t     wscale;

  out_item_t   expected_headers[$];

  task automatic note_mismatch(input string what);
    $display("%0t: header mismatch: %s", $time, what);
    errors++;
  endtask

  task automatic check_field(input string name, input logic [31:0] got,
                             input logic [31:0] want);
    if (got !== want)
      note_mismatch($sformatf("%s got %0h, want %0h", name, got, want));
  endtask

  task automatic clear_frame();
    frame_pos  = '0;
    src_ip     = '0;
    dst_ip     = '0;
    src_port   = '0;
    dst_port   = '0;
    seq_no     = '0;
    ack_no     = '0;
    tcp_flags  = '0;
    rx_window  = '0;
    hdr_len    = '0;
    walk_phase = PH_KIND;
    opt_left   = '0;
    opt_kind   = '0;
    wscale     = '0;
  endtask

  // Advance the option walk by one byte
  task automatic walk_option(input logic [7:0] b);
    int rem;
    case (walk_phase)
      PH_KIND: begin
        opt_kind = b;
        if (b == KIND_END) walk_phase = PH_DONE;
        else if (b != KIND_NOP) walk_phase = PH_LEN;
      end
      PH_LEN: begin
        if (b < OPT_MIN_LEN) begin
          walk_phase = PH_DONE;
        end else begin
          rem = int'(b) - int'(OPT_MIN_LEN);
          opt_left = (rem > REM_MAX) ? REM_MAX[5:0] : rem[5:0];
          walk_phase = (opt_left != '0) ? PH_DATA : PH_KIND;
        end
      end
      PH_DATA: begin
        if (opt_kind == KIND_WSCALE && !wscale.seen) wscale = '{seen: 1'b1, value: b};
        opt_left = opt_left - 6'd1;
        if (opt_left == '0) walk_phase = PH_KIND;
      end
      default: ;
    endcase
  endtask

  task automatic track_frame_byte(input logic [7:0] b, input logic last);
    int p, ofs, need;
    out_item_t hdr;
    p = int'(frame_pos);
    if (p >= ETH_HEADER_BYTES && p < TCP_START) begin
      ofs = p - ETH_HEADER_BYTES;
      if (ofs >= IP_SRC_OFS && ofs < IP_SRC_OFS + 4)
        src_ip[8 * (3 - (ofs - IP_SRC_OFS)) +: 8] = b;
      else if (ofs >= IP_DST_OFS && ofs < IP_DST_OFS + 4)
        dst_ip[8 * (3 - (ofs - IP_DST_OFS)) +: 8] = b;
    end else if (p >= TCP_START && p < POS_MAX) begin
      ofs = p - TCP_START;
      if (ofs < 2) src_port[8 * (1 - ofs) +: 8] = b;
      else if (ofs < TCP_SEQ_OFS) dst_port[8 * (3 - ofs) +: 8] = b;
      else if (ofs < TCP_ACK_OFS) seq_no[8 * (3 - (ofs - TCP_SEQ_OFS)) +: 8] = b;
      else if (ofs < TCP_DOFF_OFS) ack_no[8 * (3 - (ofs - TCP_ACK_OFS)) +: 8] = b;
      else if (ofs == TCP_DOFF_OFS) hdr_len = {b[7:4], 2'b00};
      else if (ofs == TCP_FLAGS_OFS) tcp_flags = b[5:0];
      else if (ofs == TCP_WIN_HI_OFS) rx_window[15:8] = b;
      else if (ofs == TCP_WIN_LO_OFS) rx_window[7:0] = b;
      else if (ofs >= TCP_MIN_HDR && ofs < int'(hdr_len) && walk_phase != PH_DONE)
        walk_option(b);
    end
    if (int'(frame_pos) < POS_MAX) frame_pos++;

    if (last) begin
      need = TCP_START + ((int'(hdr_len) > TCP_MIN_HDR) ? int'(hdr_len) : TCP_MIN_HDR);
      hdr.source_address   = src_ip;
      hdr.dest_address     = dst_ip;
      hdr.source_port      = src_port;
      hdr.dest_port        = dst_port;
      hdr.sequence_number  = seq_no;
      hdr.ack_number       = ack_no;
      hdr.flag_bits        = tcp_flags;
      hdr.window_size      = rx_window;
      hdr.tcp_header_bytes = hdr_len;
      hdr.has_window_scale = wscale.seen;
      hdr.window_scale     = wscale.value;
      hdr.status           = (p + 1 < need);
      expected_headers.insert(expected_headers.size(), hdr);
      clear_frame();
    end
  endtask

  task automatic check_header(input out_item_t got);
    out_item_t want;
    if (expected_headers.size() == 0) begin
      note_mismatch("result item with no frame closed");
      return;
    end
    want = expected_headers.pop_front();
    check_field("source_address", got.source_address, want.source_address);
    check_field("dest_address", got.dest_address, want.dest_address);
    check_field("source_port", 32'(got.source_port), 32'(want.source_port));
    check_field("dest_port", 32'(got.dest_port), 32'(want.dest_port));
    check_field("sequence_number", got.sequence_number, want.sequence_number);
    check_field("ack_number", got.ack_number, want.ack_number);
    check_field("flag_bits", 32'(got.flag_bits), 32'(want.flag_bits));
    check_field("window_size", 32'(got.window_size), 32'(want.window_size));
    check_field("tcp_header_bytes", 32'(got.tcp_header_bytes),
                32'(want.tcp_header_bytes));
    check_field("has_window_scale", 32'(got.has_window_scale),
                32'(want.has_window_scale));
    check_field("window_scale", 32'(got.window_scale), 32'(want.window_scale));
    check_field("status", 32'(got.status), 32'(want.status));
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      clear_frame();
      expected_headers.delete();
    end else begin
      if (in_valid && !in_stall) track_frame_byte(in_item.data_byte, in_item.last_byte);
      if (out_valid && !out_stall) check_header(out_item);
    end
    headers_due = expected_headers.size();
  end

endmodule

@@ tb/testbench.sv @@
// ----------------------------------------------------------------------------
// TCP/IPv4 header extractor testbench
// Feeds directed and random Ethernet/IPv4/TCP frames byte by byte with random
// gaps and output stalls, including one long output hold-off; the checker
// predicts every header and the top reports the verdict.
// ----------------------------------------------------------------------------
module testbench;
  import tcphdr_pkg::*;

  localparam int ITEM_GOAL   = 1450;    // bytes to send over the whole run
  localparam int HOLD_CYCLES = 300;     // long output hold-off
  localparam int CYCLE_LIMIT = 400000;  // generous bound on the whole run

  // Option kinds and lengths used to shape frames beyond the package codes
  localparam logic [7:0] OPT_MSS       = 8'd2;
  localparam logic [7:0] OPT_SACK_OK   = 8'd4;
  localparam logic [7:0] OPT_TIMESTAMP = 8'd8;
  localparam logic [7:0] LEN_WSCALE    = 8'd3;
  localparam logic [7:0] LEN_MSS       = 8'd4;
  localparam logic [7:0] LEN_TIMESTAMP = 8'd10;

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_stall;
  in_item_t  in_item;
  logic      out_valid;
  logic      out_stall;
  out_item_t out_item;

  int errors;
  int headers_due;

  logic hold_req;      // stimulus asks for the long hold-off
  logic hold_active;   // stall driver is inside the hold-off

  logic [7:0] frame_q[$];  // bytes of the frame being built
  int items_sent;
  int calm_left;           // bytes still to send back to back
  int cycles;

  tcp_ipv4_header_extractor DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

  header_checker u_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_item     (in_item),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_item    (out_item),
    .errors      (errors),
    .headers_due (headers_due)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Bound the run: a hang or a lost result ends here
  initial begin
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("CHECKS FAILED");
    $finish;
  end

  // Output stall driver: short stalls mostly, a few long ones, stretches with
  // no stall at all, and once the long hold-off that backs up the block.
  initial begin
    int r;
    out_stall   = 1'b0;
    hold_active = 1'b0;
    wait (rst_n === 1'b1);
    @(negedge clk);
    forever begin
      if (hold_req && !hold_active) begin
        // Hold for a fixed count so the block fills and stalls its input
        hold_active = 1'b1;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
      end else begin
        r = $urandom_range(0, 99);
        if (r < 15) begin
          out_stall <= 1'b0;
          repeat ($urandom_range(20, 80)) @(negedge clk);
        end else if (r < 90) begin
          out_stall <= 1'b1;
          repeat ($urandom_range(1, 3)) @(negedge clk);
          out_stall <= 1'b0;
          repeat ($urandom_range(1, 6)) @(negedge clk);
        end else begin
          out_stall <= 1'b1;
          repeat ($urandom_range(10, 40)) @(negedge clk);
          out_stall <= 1'b0;
          repeat ($urandom_range(1, 4)) @(negedge clk);
        end
      end
    end
  end

  // Offer one byte at a falling edge and hold it until it is accepted; outside
  // a back-to-back stretch, sometimes insert a random gap first.
  task automatic send_byte(input logic [7:0] b, input logic last);
    int r;
    if (calm_left > 0) begin
      calm_left--;
    end else begin
      r = $urandom_range(0, 99);
      if (r < 4) begin
        calm_left = $urandom_range(20, 120);
      end else if (r >= 70) begin
        in_valid <= 1'b0;
        repeat ((r < 96) ? $urandom_range(1, 3) : $urandom_range(10, 40)) @(negedge clk);
      end
    end
    in_item  <= '{data_byte: b, last_byte: last};
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
    items_sent++;
  endtask

  task automatic send_frame();
    for (int i = 0; i < frame_q.size(); i++)
      send_byte(frame_q[i], i == frame_q.size() - 1);
  endtask

  // Add one byte at the end of the frame
  task automatic append_byte(input logic [7:0] v);
    frame_q.insert(frame_q.size(), v);
  endtask

  // Append random bytes until the frame holds n bytes
  task automatic pad_to(input int n);
    while (frame_q.size() < n) append_byte(8'($urandom_range(0, 255)));
  endtask

  task automatic fill_frame(input logic [7:0] v, input int n);
    frame_q.delete();
    repeat (n) append_byte(v);
  endtask

  // Start a frame: random Ethernet, IPv4 and base TCP header with the given
  // data offset nibble and a random low nibble beside it.
  task automatic build_header(input logic [3:0] doff);
    frame_q.delete();
    pad_to(TCP_START + TCP_DOFF_OFS);
    append_byte({doff, 4'($urandom_range(0, 15))});
    pad_to(TCP_START + TCP_MIN_HDR);
  endtask

  // Append one option: kind, length, then the first data byte and random rest
  task automatic add_option(input logic [7:0] kind, input logic [7:0] len,
                            input logic [7:0] first);
    append_byte(kind);
    append_byte(len);
    if (len > OPT_MIN_LEN) begin
      append_byte(first);
      pad_to(frame_q.size() + int'(len) - 3);
    end
  endtask

  // Fill the option area with a random mix of options; trim at its end so the
  // walk bound falls inside options as often as not.
  task automatic add_random_options(input int area_end);
    int r;
    while (frame_q.size() < area_end) begin
      r = $urandom_range(0, 99);
      if (r < 20) append_byte(KIND_NOP);
      else if (r < 24) append_byte(KIND_END);
      else if (r < 50) add_option(KIND_WSCALE, LEN_WSCALE, 8'($urandom_range(0, 255)));
      else if (r < 55) add_option(KIND_WSCALE, OPT_MIN_LEN, 8'h00);
      else if (r < 63) add_option(OPT_MSS, LEN_MSS, 8'($urandom_range(0, 255)));
      else if (r < 70) add_option(OPT_SACK_OK, OPT_MIN_LEN, 8'h00);
      else if (r < 78) add_option(OPT_TIMESTAMP, LEN_TIMESTAMP, 8'($urandom_range(0, 255)));
      else if (r < 90)
        add_option(8'($urandom_range(0, 255)), 8'($urandom_range(2, 12)),
                   8'($urandom_range(0, 255)));
      else if (r < 95) add_option(8'($urandom_range(0, 255)), 8'($urandom_range(0, 1)), 8'h00);
      else begin
        // Raw kind and length, large lengths included
        append_byte(8'($urandom_range(0, 255)));
        append_byte(8'($urandom_range(0, 255)));
      end
    end
    while (frame_q.size() > area_end) frame_q.delete(frame_q.size() - 1);
  endtask

  task automatic make_random_frame();
    int r;
    logic [3:0] doff;
    r = $urandom_range(0, 99);
    if (r < 10) begin
      // Noise: a short frame of arbitrary bytes
      frame_q.delete();
      pad_to($urandom_range(1, 80));
      return;
    end
    doff = ($urandom_range(0, 99) < 85) ? 4'($urandom_range(5, 15))
                                        : 4'($urandom_range(0, 15));
    build_header(doff);
    if (doff > 4'd5) add_random_options(TCP_START + 4 * int'(doff));
    r = $urandom_range(0, 99);
    if (r < 85) pad_to(frame_q.size() + $urandom_range(0, 6));
    else if (r < 95) pad_to(frame_q.size() + $urandom_range(7, 40));
    else pad_to($urandom_range(128, 200));
    // Cut some frames short to exercise truncation
    if ($urandom_range(0, 99) < 30) begin
      r = $urandom_range(1, frame_q.size());
      while (frame_q.size() > r) frame_q.delete(frame_q.size() - 1);
    end
  endtask

  initial begin
    rst_n       = 1'b0;
    in_valid    = 1'b0;
    in_item     = '0;
    hold_req    = 1'b0;
    calm_left   = 0;
    items_sent  = 0;
    repeat (2) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed frames
    // Single byte frame: everything reads zero, header incomplete
    frame_q.delete();
    append_byte(8'hFF);
    send_frame();
    // All ones through a 60-byte TCP header
    fill_frame(8'hFF, TCP_START + 60);
    send_frame();
    // All zeros: data offset zero, complete at the base header
    fill_frame(8'h00, TCP_START + TCP_MIN_HDR);
    send_frame();
    // One byte short of the base TCP header
    build_header(4'd5);
    frame_q.delete(frame_q.size() - 1);
    send_frame();
    // Full option list: MSS, scale, short scale, second scale, unknown, end
    build_header(4'd15);
    append_byte(KIND_NOP);
    add_option(OPT_MSS, LEN_MSS, 8'h05);
    add_option(KIND_WSCALE, LEN_WSCALE, 8'd14);
    add_option(KIND_WSCALE, OPT_MIN_LEN, 8'h00);
    add_option(KIND_WSCALE, LEN_WSCALE, 8'd7);
    add_option(8'd200, 8'd6, 8'($urandom_range(0, 255)));
    append_byte(KIND_END);
    add_option(KIND_WSCALE, LEN_WSCALE, 8'd9);
    pad_to(TCP_START + 60);
    pad_to(frame_q.size() + 5);
    send_frame();
    // Bad option length stops the walk before a scale option
    build_header(4'd8);
    add_option(OPT_TIMESTAMP, 8'd1, 8'h00);
    add_option(KIND_WSCALE, LEN_WSCALE, 8'd9);
    pad_to(TCP_START + 32);
    send_frame();
    // Scale data byte lands just past the data offset: not taken
    build_header(4'd6);
    append_byte(KIND_NOP);
    append_byte(KIND_NOP);
    append_byte(KIND_WSCALE);
    append_byte(LEN_WSCALE);
    pad_to(frame_q.size() + 9);
    send_frame();
    // Maximum option length clamps, frame runs far past the position limit
    build_header(4'd15);
    add_option(KIND_WSCALE, LEN_WSCALE, 8'hFF);
    add_option(8'd5, 8'd255, 8'h00);
    send_frame();
    // Frame ends inside the options after the scale was seen
    build_header(4'd15);
    add_option(KIND_WSCALE, LEN_WSCALE, 8'd5);
    pad_to(TCP_START + 30);
    send_frame();
    // Small data offset: reported as is, no options walked
    build_header(4'd4);
    send_frame();
    // Frame ends inside the source address
    frame_q.delete();
    pad_to(ETH_HEADER_BYTES + IP_SRC_OFS + 2);
    send_frame();

    // Long hold-off: wait for it to start, then offer tiny frames so closing
    // bytes pile up behind the held result and the input stalls
    hold_req = 1'b1;
    wait (hold_active === 1'b1);
    @(negedge clk);
    repeat (40) begin
      frame_q.delete();
      pad_to($urandom_range(1, 3));
      send_frame();
    end

    // Random frames until the byte budget is spent
    while (items_sent < ITEM_GOAL) begin
      make_random_frame();
      send_frame();
    end
    in_valid <= 1'b0;

    // Drain, then give a stray result time to show up
    while (headers_due != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    @(negedge clk);
    if (errors == 0) $display("ALL CHECKS PASSED");
    else $display("CHECKS FAILED");
    $finish;
  end

endmodule

@@ sim.f @@
+incdir+hdl
hdl/tcphdr_pkg.sv
hdl/tcphdr_opt_walk.sv
hdl/tcp_ipv4_header_extractor.sv
tb/header_checker.sv
tb/testbench.sv
